### src/ymf_pkg.sv
// ----------------------------------------------------------------------------
// ymf_pkg
// Types, codes and constants shared by the YMODEM frame receiver.
// ----------------------------------------------------------------------------
package ymf_pkg;

  localparam int unsigned SHORT_DATA_BYTES = 128;
  localparam int unsigned LONG_DATA_BYTES  = 1024;

  localparam int unsigned POS_W = 11;
  localparam int unsigned IDX_W = 10;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_WAIT       = POS_W'(0);
  localparam pos_t POS_BLOCK      = POS_W'(1);
  localparam pos_t POS_COMPL      = POS_W'(2);
  localparam pos_t POS_DATA       = POS_W'(3);
  localparam pos_t POS_SHORT_CRCH = POS_W'(3 + SHORT_DATA_BYTES);
  localparam pos_t POS_LONG_CRCH  = POS_W'(3 + LONG_DATA_BYTES);

  localparam logic [7:0] LEAD_SOH = 8'h01;
  localparam logic [7:0] LEAD_STX = 8'h02;
  localparam logic [7:0] LEAD_EOT = 8'h04;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [8:0]  COMPL_SUM = 9'h0ff;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_GOOD     = 3'd0,
    VERDICT_CRC_ERR  = 3'd1,
    VERDICT_END_NULL = 3'd2,
    VERDICT_EOT_NAK  = 3'd3,
    VERDICT_EOT_ACK  = 3'd4,
    VERDICT_DISCARD  = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    END_NONE = 2'd0,
    END_ONE  = 2'd1,
    END_TWO  = 2'd2
  } end_seq_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic             out_kind;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic [7:0]       block_number;
    logic             long_packet;
    verdict_t         verdict;
  } out_word_t;

  typedef struct packed {
    logic     advance;
    in_word_t word;
  } frm_ctrl_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/ymf_in_reg.sv
// ----------------------------------------------------------------------------
// ymf_in_reg
// Input register: holds one received word until the framer consumes it.
// ----------------------------------------------------------------------------
module ymf_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  ymf_pkg::in_word_t byte_word,
  input  logic              advance,
  output logic              held_valid,
  output ymf_pkg::in_word_t held_word
);

  logic accept;

  assign byte_stall = held_valid && !advance;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_word <= byte_word;
    end
  end

endmodule

### src/ymf_framer.sv
// ----------------------------------------------------------------------------
// ymf_framer
// Packet framing state, bytewise CRC and verdict logic.
// ----------------------------------------------------------------------------
module ymf_framer (
  input  logic               clk,
  input  logic               rst,
  input  ymf_pkg::frm_ctrl_t ctrl,
  output logic               has_result,
  output ymf_pkg::out_word_t result
);

  ymf_pkg::pos_t     pos, pos_next;
  logic              is_long, is_long_next;
  logic [7:0]        block_byte, block_byte_next;
  logic [7:0]        compl_byte, compl_byte_next;
  logic [15:0]       crc, crc_next;
  logic [7:0]        crc_high, crc_high_next;
  ymf_pkg::end_seq_t end_seq, end_seq_next;

  ymf_pkg::pos_t crc_high_pos;
  logic [7:0]    b;
  logic [15:0]   rx_crc;
  logic [8:0]    compl_sum;

  assign b            = ctrl.word.rx_byte;
  assign crc_high_pos = is_long ? ymf_pkg::POS_LONG_CRCH : ymf_pkg::POS_SHORT_CRCH;
  assign rx_crc       = {crc_high, b};
  assign compl_sum    = {1'b0, block_byte} + {1'b0, compl_byte};

  always_comb begin
    pos_next        = pos;
    is_long_next    = is_long;
    block_byte_next = block_byte;
    compl_byte_next = compl_byte;
    crc_next        = crc;
    crc_high_next   = crc_high;
    end_seq_next    = end_seq;
    has_result      = 1'b0;
    result          = '0;
    if (ctrl.word.mode) begin
      pos_next        = ymf_pkg::POS_WAIT;
      is_long_next    = 1'b0;
      block_byte_next = '0;
      compl_byte_next = '0;
      crc_next        = '0;
      crc_high_next   = '0;
      end_seq_next    = ymf_pkg::END_NONE;
    end else if (pos == ymf_pkg::POS_WAIT) begin
      if (b == ymf_pkg::LEAD_SOH || b == ymf_pkg::LEAD_STX) begin
        is_long_next = (b == ymf_pkg::LEAD_STX);
        crc_next     = '0;
        pos_next     = ymf_pkg::POS_BLOCK;
      end else if (b == ymf_pkg::LEAD_EOT) begin
        case (end_seq)
          ymf_pkg::END_NONE: begin
            end_seq_next     = ymf_pkg::END_ONE;
            has_result       = 1'b1;
            result.out_kind  = ymf_pkg::KIND_VERDICT;
            result.verdict   = ymf_pkg::VERDICT_EOT_NAK;
          end
          ymf_pkg::END_ONE: begin
            end_seq_next     = ymf_pkg::END_TWO;
            has_result       = 1'b1;
            result.out_kind  = ymf_pkg::KIND_VERDICT;
            result.verdict   = ymf_pkg::VERDICT_EOT_ACK;
          end
          default: begin
          end
        endcase
      end
    end else if (pos == ymf_pkg::POS_BLOCK) begin
      block_byte_next = b;
      pos_next        = ymf_pkg::POS_COMPL;
    end else if (pos == ymf_pkg::POS_COMPL) begin
      compl_byte_next = b;
      pos_next        = ymf_pkg::POS_DATA;
    end else if (pos < crc_high_pos) begin
      crc_next             = ymf_pkg::crc_byte(crc, b);
      pos_next             = pos + ymf_pkg::POS_W'(1);
      has_result           = 1'b1;
      result.out_kind      = ymf_pkg::KIND_PAYLOAD;
      result.payload_byte  = b;
      result.payload_index = ymf_pkg::IDX_W'(pos - ymf_pkg::POS_DATA);
      result.block_number  = block_byte;
      result.long_packet   = is_long;
      result.verdict       = ymf_pkg::VERDICT_GOOD;
    end else if (pos == crc_high_pos) begin
      crc_high_next = b;
      pos_next      = pos + ymf_pkg::POS_W'(1);
    end else begin
      pos_next            = ymf_pkg::POS_WAIT;
      has_result          = 1'b1;
      result.out_kind     = ymf_pkg::KIND_VERDICT;
      result.block_number = block_byte;
      result.long_packet  = is_long;
      if (compl_sum != ymf_pkg::COMPL_SUM) begin
        result.verdict = ymf_pkg::VERDICT_DISCARD;
      end else if (end_seq == ymf_pkg::END_TWO && block_byte == 8'h00) begin
        result.verdict = ymf_pkg::VERDICT_END_NULL;
      end else if (rx_crc == crc) begin
        result.verdict = ymf_pkg::VERDICT_GOOD;
      end else begin
        result.verdict = ymf_pkg::VERDICT_CRC_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= ymf_pkg::POS_WAIT;
      is_long    <= 1'b0;
      block_byte <= '0;
      compl_byte <= '0;
      crc        <= '0;
      crc_high   <= '0;
      end_seq    <= ymf_pkg::END_NONE;
    end else if (ctrl.advance) begin
      pos        <= pos_next;
      is_long    <= is_long_next;
      block_byte <= block_byte_next;
      compl_byte <= compl_byte_next;
      crc        <= crc_next;
      crc_high   <= crc_high_next;
      end_seq    <= end_seq_next;
    end
  end

endmodule

### src/ymf_out_reg.sv
// ----------------------------------------------------------------------------
// ymf_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module ymf_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ymf_pkg::out_word_t load_word,
  output logic               result_valid,
  input  logic               result_stall,
  output ymf_pkg::out_word_t result_word,
  output logic               free
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_word <= load_word;
    end
  end

endmodule

### src/ymodem_frame_receiver.sv
// Data path: input register, combinational framer, result register.
// Throughput: one word per cycle; the framer consumes a held word whenever
// the result register is empty or being drained.
// Reset: synchronous; clears framing, CRC, end sequence and both valid flags.
// ----------------------------------------------------------------------------
// ymodem_frame_receiver
// YMODEM packet framer with CRC-16/XMODEM check and EOT end sequence.
// ----------------------------------------------------------------------------
module ymodem_frame_receiver (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  ymf_pkg::in_word_t  byte_word,
  output logic               result_valid,
  input  logic               result_stall,
  output ymf_pkg::out_word_t result_word
);

  logic               held_valid;
  ymf_pkg::in_word_t  held_word;
  logic               free;
  logic               has_result;
  ymf_pkg::out_word_t frm_result;
  ymf_pkg::frm_ctrl_t ctrl;

  assign ctrl.advance = held_valid && free;
  assign ctrl.word    = held_word;

  ymf_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .advance    (ctrl.advance),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  ymf_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .has_result (has_result),
    .result     (frm_result)
  );

  ymf_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (ctrl.advance && has_result),
    .load_word    (frm_result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .free         (free)
  );

endmodule
